FILE: sv/iets_pkg.sv
// shared types and constants for the information element tag search
`default_nettype none

package iets_pkg;

  // largest area length honored, longer areas are clipped to it
  localparam int MAX_AREA_BYTES = 4095;

  // clip limit as a 12-bit value, at most the field range
  localparam logic [11:0] AREA_CAP =
    12'(MAX_AREA_BYTES > 4095 ? 4095 : MAX_AREA_BYTES);

  // byte position saturates here
  localparam logic [11:0] POS_MAX = 12'hFFF;

  // scan phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_NUMBER = 3'd1,
    PH_LENGTH = 3'd2,
    PH_DATA   = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

endpackage

`default_nettype wire

FILE: sv/info_element_tag_search.sv
// top level of the information element tag search
`default_nettype none

// Walks an 802.11 tagged-parameter area one byte word per cycle and passes out
// the data bytes of the first element whose number equals the configured tag
// and whose length fits in the rest of the area. A new area begins on a word
// with in_tuser high; its length is taken from that word. Each accepted word
// is handled by a compare and a 14-bit add in front of the output register,
// so one word is taken every clock, and a result is registered there and appears
// in the cycle after the word that causes it. The output register is the only
// buffer: input is held off only while a result sits there and out_tready is low.
// A zero-length match gives one word of kind empty on its length byte, and an
// area without a usable match gives one word of kind not-found, on the length
// byte of the last element looked at or on the start word of a short area.
module info_element_tag_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,   // wanted_tag
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,      // area_byte[7:0], area_length[19:8], zero pad
  input  wire logic        in_tuser,      // area_start
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,     // element_byte[7:0], element_length[15:8],
                                          // element_offset[27:16], zero pad
  output logic [1:0]       out_tuser,     // result_kind
  output logic             out_tlast      // element_last
);

  // configuration register
  logic [7:0] wanted_tag_r;

  // scan state
  iets_pkg::phase_t phase_r, phase_nxt;
  logic [11:0] pos_r, pos_nxt;
  logic [11:0] nha_r, nha_nxt;
  logic        matched_r, matched_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  flen_r, flen_nxt;
  logic [11:0] foff_r, foff_nxt;
  logic [11:0] hal_r, hal_nxt;

  // output register
  logic        out_valid_r;
  logic [7:0]  out_byte_r, out_len_r;
  logic [11:0] out_off_r;
  logic [1:0]  out_kind_r;
  logic        out_last_r;

  // field unpacking
  logic [7:0]  in_byte;
  logic [11:0] in_alen;
  logic        in_start;
  logic        accept;

  assign in_byte  = in_tdata[7:0];
  assign in_alen  = in_tdata[19:8];
  assign in_start = in_tuser;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // per-word helpers
  logic [11:0] alen_clip;
  logic        area_short;
  logic [11:0] pos_inc;
  logic [11:0] room;
  logic        hit;
  logic [13:0] nxt_w;
  logic        end_hit;
  logic [7:0]  rem_dec;
  logic        tag_eq;

  assign alen_clip  = (in_alen > iets_pkg::AREA_CAP) ? iets_pkg::AREA_CAP : in_alen;
  assign area_short = !(alen_clip > 12'd2);
  assign pos_inc    = (pos_r < iets_pkg::POS_MAX) ? pos_r + 12'd1 : pos_r;
  assign room       = hal_r - nha_r - 12'd2;
  assign hit        = matched_r && ({4'd0, in_byte} <= room);
  assign nxt_w      = {2'd0, nha_r} + 14'd2 + {6'd0, in_byte};
  assign end_hit    = (nxt_w + 14'd2) >= {2'd0, hal_r};
  assign rem_dec    = (rem_r != 8'd0) ? rem_r - 8'd1 : rem_r;
  assign tag_eq     = (in_byte == wanted_tag_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_start) begin
        phase_nxt = area_short ? iets_pkg::PH_DONE : iets_pkg::PH_LENGTH;
      end else begin
        unique case (phase_r)
          iets_pkg::PH_NUMBER: begin
            if (pos_inc == nha_r) phase_nxt = iets_pkg::PH_LENGTH;
          end
          iets_pkg::PH_LENGTH: begin
            if (hit) begin
              phase_nxt = (in_byte == 8'd0) ? iets_pkg::PH_DONE : iets_pkg::PH_DATA;
            end else begin
              phase_nxt = end_hit ? iets_pkg::PH_DONE : iets_pkg::PH_NUMBER;
            end
          end
          iets_pkg::PH_DATA: begin
            if (rem_dec == 8'd0) phase_nxt = iets_pkg::PH_DONE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // datapath and result
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte, res_len;
  logic [11:0] res_off;
  logic        res_last;

  always_comb begin
    pos_nxt     = pos_r;
    nha_nxt     = nha_r;
    matched_nxt = matched_r;
    rem_nxt     = rem_r;
    flen_nxt    = flen_r;
    foff_nxt    = foff_r;
    hal_nxt     = hal_r;
    res_valid   = 1'b0;
    res_kind    = iets_pkg::KIND_NONE;
    res_byte    = 8'd0;
    res_len     = 8'd0;
    res_off     = 12'd0;
    res_last    = 1'b0;
    if (accept) begin
      if (in_start) begin
        hal_nxt     = alen_clip;
        pos_nxt     = 12'd0;
        nha_nxt     = 12'd0;
        rem_nxt     = 8'd0;
        flen_nxt    = 8'd0;
        foff_nxt    = 12'd0;
        matched_nxt = !area_short && tag_eq;
        // short area: not found at once
        res_valid   = area_short;
      end else if (phase_r != iets_pkg::PH_IDLE && phase_r != iets_pkg::PH_DONE) begin
        pos_nxt = pos_inc;
        case (phase_r)
          iets_pkg::PH_NUMBER: begin
            if (pos_inc == nha_r) matched_nxt = tag_eq;
          end
          iets_pkg::PH_LENGTH: begin
            if (hit) begin
              flen_nxt = in_byte;
              foff_nxt = nha_r;
              rem_nxt  = in_byte;
              // zero-length match
              if (in_byte == 8'd0) begin
                res_valid = 1'b1;
                res_kind  = iets_pkg::KIND_EMPTY;
                res_off   = nha_r;
              end
            end else if (end_hit) begin
              res_valid = 1'b1;
            end else begin
              nha_nxt = nxt_w[11:0];
            end
          end
          iets_pkg::PH_DATA: begin
            rem_nxt   = rem_dec;
            res_valid = 1'b1;
            res_kind  = iets_pkg::KIND_DATA;
            res_byte  = in_byte;
            res_last  = (rem_r == 8'd1);
            res_len   = flen_r;
            res_off   = foff_r;
          end
          default: begin
            pos_nxt = pos_inc;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_tag_r <= 8'd0;
      phase_r      <= iets_pkg::PH_IDLE;
      pos_r        <= 12'd0;
      nha_r        <= 12'd0;
      matched_r    <= 1'b0;
      rem_r        <= 8'd0;
      flen_r       <= 8'd0;
      foff_r       <= 12'd0;
      hal_r        <= 12'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) wanted_tag_r <= cfg_wr_data;
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      nha_r     <= nha_nxt;
      matched_r <= matched_nxt;
      rem_r     <= rem_nxt;
      flen_r    <= flen_nxt;
      foff_r    <= foff_nxt;
      hal_r     <= hal_nxt;
      if (accept) begin
        out_valid_r <= res_valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_last_r <= res_last;
      out_len_r  <= res_len;
      out_off_r  <= res_off;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_off_r, out_len_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
